// ----- rtl/suv_pkg.sv -----
// shared types and constants for the strict utf-8 validator
// no dependencies; used by suv_decode and strict_utf8_validator
package suv_pkg;

  localparam int unsigned CpBits  = 21;
  localparam int unsigned DueBits = 2;
  localparam int unsigned LenBits = 3;

  localparam logic [CpBits-1:0] CpMin2     = 21'h00080;
  localparam logic [CpBits-1:0] CpMin3     = 21'h00800;
  localparam logic [CpBits-1:0] CpMin4     = 21'h10000;
  localparam logic [CpBits-1:0] CpSurroLo  = 21'h0D800;
  localparam logic [CpBits-1:0] CpSurroHi  = 21'h0DFFF;
  localparam logic [CpBits-1:0] CpMax      = 21'h10FFFF;

  localparam logic [LenBits-1:0] SeqLen2 = 3'd2;
  localparam logic [LenBits-1:0] SeqLen3 = 3'd3;
  localparam logic [LenBits-1:0] SeqLen4 = 3'd4;

  // byte classes seen when no sequence is open
  typedef enum logic [2:0] {
    LeadAscii,
    LeadTwo,
    LeadThree,
    LeadFour,
    LeadBad
  } lead_e;

  // decoder state other than the offsets
  typedef struct packed {
    logic [DueBits-1:0] due;
    logic [LenBits-1:0] len;
    logic [CpBits-1:0]  acc;
    logic               err;
  } ctl_t;

  function automatic lead_e classify(input logic [7:0] b);
    lead_e k;
    if (b[7] == 1'b0) begin
      k = LeadAscii;
    end else if (b[7:5] == 3'b110) begin
      k = LeadTwo;
    end else if (b[7:4] == 4'b1110) begin
      k = LeadThree;
    end else if (b[7:3] == 5'b11110) begin
      k = LeadFour;
    end else begin
      k = LeadBad;
    end
    return k;
  endfunction

endpackage

// ----- rtl/suv_decode.sv -----
// next-state and result logic for one byte of the utf-8 validator
// depends on suv_pkg (ctl_t, lead_e, code point limits)
module suv_decode #(
  parameter int unsigned OffsetBits = 32
) (
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  suv_pkg::ctl_t         ctl_i,
  input  logic [OffsetBits-1:0] pos_i,
  input  logic [OffsetBits-1:0] start_i,
  input  logic [OffsetBits-1:0] epos_i,
  output suv_pkg::ctl_t         ctl_o,
  output logic [OffsetBits-1:0] pos_o,
  output logic [OffsetBits-1:0] start_o,
  output logic [OffsetBits-1:0] epos_o,
  output logic                  malformed_o,
  output logic [31:0]           bad_offset_o
);

  suv_pkg::ctl_t                  c;
  logic [OffsetBits-1:0]          start;
  logic [OffsetBits-1:0]          epos;
  logic [suv_pkg::CpBits-1:0]     cp_min;
  logic [suv_pkg::CpBits-1:0]     acc_new;
  logic [OffsetBits+31:0]         epos_ext;

  assign acc_new = {ctl_i.acc[suv_pkg::CpBits-7:0], byte_i[5:0]};

  always_comb begin
    unique case (ctl_i.len)
      suv_pkg::SeqLen2: cp_min = suv_pkg::CpMin2;
      suv_pkg::SeqLen3: cp_min = suv_pkg::CpMin3;
      default:          cp_min = suv_pkg::CpMin4;
    endcase
  end

  always_comb begin
    c     = ctl_i;
    start = start_i;
    epos  = epos_i;
    if (!ctl_i.err) begin
      if (ctl_i.due == '0) begin
        unique case (suv_pkg::classify(byte_i))
          suv_pkg::LeadAscii: ;
          suv_pkg::LeadTwo: begin
            c.len = suv_pkg::SeqLen2;
            c.due = 2'd1;
            c.acc = {16'd0, byte_i[4:0]};
            start = pos_i;
          end
          suv_pkg::LeadThree: begin
            c.len = suv_pkg::SeqLen3;
            c.due = 2'd2;
            c.acc = {17'd0, byte_i[3:0]};
            start = pos_i;
          end
          suv_pkg::LeadFour: begin
            c.len = suv_pkg::SeqLen4;
            c.due = 2'd3;
            c.acc = {18'd0, byte_i[2:0]};
            start = pos_i;
          end
          default: begin
            c.err = 1'b1;
            epos  = pos_i;
            c.due = '0;
            c.len = '0;
            c.acc = '0;
          end
        endcase
      end else if (byte_i[7:6] != 2'b10) begin
        c.err = 1'b1;
        epos  = start_i;
        c.due = '0;
        c.len = '0;
        c.acc = '0;
      end else begin
        c.acc = acc_new;
        c.due = ctl_i.due - 2'd1;
        if (c.due == '0) begin
          // sequence complete: overlong, surrogate and range checks
          if (acc_new < cp_min
              || (acc_new >= suv_pkg::CpSurroLo && acc_new <= suv_pkg::CpSurroHi)
              || acc_new > suv_pkg::CpMax) begin
            c.err = 1'b1;
            epos  = start_i;
          end
          c.len = '0;
          c.acc = '0;
        end
      end
      // string ends inside an open sequence
      if (last_i && !c.err && c.due != '0) begin
        c.err = 1'b1;
        epos  = start;
        c.due = '0;
        c.len = '0;
        c.acc = '0;
      end
    end
  end

  assign epos_ext     = {32'd0, epos};
  assign malformed_o  = c.err;
  assign bad_offset_o = c.err ? epos_ext[31:0] : 32'd0;

  always_comb begin
    if (last_i) begin
      ctl_o   = '0;
      start_o = '0;
      epos_o  = '0;
      pos_o   = '0;
    end else begin
      ctl_o   = c;
      start_o = start;
      epos_o  = epos;
      pos_o   = (pos_i == {OffsetBits{1'b1}}) ? pos_i : pos_i + 1'b1;
    end
  end

endmodule

// ----- rtl/strict_utf8_validator.sv -----
// top level of the strict utf-8 validator: input register, state, result register
// depends on suv_pkg and suv_decode
//
// channel   direction  tdata                        tuser          tlast
// s_axis    in         [7:0] data_byte              -              end_of_string
// m_axis    out        [31:0] bad_offset            [0] malformed  -
//
// one byte per cycle sustained while no final byte waits: a byte is held in
// the input register, is decoded against the stream state and, if it ends
// the string, leaves its result in the output register
// a byte without end_of_string never waits on m_axis; a final byte waits in
// the input register only while an earlier result is still held
// reset clears the stream state and both valid flags; after each final byte
// the state returns to its reset values for the next string
module strict_utf8_validator #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] bad_offset
  output logic [0:0]  m_axis_tuser    // [0] malformed
);

  // input register
  logic                   in_vld_q, in_vld_d;
  logic [7:0]             in_byte_q;
  logic                   in_last_q;

  // stream state
  suv_pkg::ctl_t          ctl_q, ctl_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] epos_q, epos_d;

  // result register
  logic                   out_vld_q, out_vld_d;
  logic                   out_mal_q;
  logic [31:0]            out_off_q;
  logic                   res_mal;
  logic [31:0]            res_off;

  logic                   advance;
  logic                   take_in;

  // a held byte moves on unless it would produce a result with no room for it
  assign advance       = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;

  suv_decode #(
    .OffsetBits(OFFSET_BITS)
  ) u_decode (
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .ctl_i       (ctl_q),
    .pos_i       (pos_q),
    .start_i     (start_q),
    .epos_i      (epos_q),
    .ctl_o       (ctl_d),
    .pos_o       (pos_d),
    .start_o     (start_d),
    .epos_o      (epos_d),
    .malformed_o (res_mal),
    .bad_offset_o(res_off)
  );

  always_comb begin
    if (advance && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ctl_q     <= '0;
      pos_q     <= '0;
      start_q   <= '0;
      epos_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        ctl_q   <= ctl_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        epos_q  <= epos_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_mal_q <= res_mal;
      out_off_q <= res_off;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_off_q;
  assign m_axis_tuser[0] = out_mal_q;

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the strict utf-8 validator, driven over both stream ports
// depends on suv_pkg and the strict_utf8_validator rtl; predicts each verdict in a scoreboard
module tb_top;

  localparam int unsigned OFFSET_BITS = 32;
  localparam logic [63:0] POS_MAX     = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int unsigned HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int unsigned PHASE_BYTES = 100;   // random bytes per flow-control phase

  typedef logic [7:0] u8_t;

  // scoreboard: tracks the decoder state of the current string and the verdicts due
  class utf8_scoreboard;
    typedef struct {
      bit          malformed;
      logic [31:0] offset;
    } verdict_t;

    verdict_t      verdict_q[$];
    logic [63:0]   byte_pos;
    logic [63:0]   seq_start;
    logic [63:0]   err_pos;
    int unsigned   due;
    int unsigned   seq_len;
    logic [20:0]   cp_acc;
    bit            err_seen;
    int unsigned   n_fail;
    int unsigned   n_results;
    int unsigned   n_malformed;

    function new();
      n_fail      = 0;
      n_results   = 0;
      n_malformed = 0;
      restart();
    endfunction

    function void restart();
      byte_pos  = '0;
      seq_start = '0;
      err_pos   = '0;
      due       = 0;
      seq_len   = 0;
      cp_acc    = '0;
      err_seen  = 1'b0;
    endfunction

    function void report(string msg);
      n_fail++;
      if (n_fail <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function suv_pkg::lead_e lead_kind(u8_t b);
      if ((b & 8'h80) == 8'h00) return suv_pkg::LeadAscii;
      if ((b & 8'hE0) == 8'hC0) return suv_pkg::LeadTwo;
      if ((b & 8'hF0) == 8'hE0) return suv_pkg::LeadThree;
      if ((b & 8'hF8) == 8'hF0) return suv_pkg::LeadFour;
      return suv_pkg::LeadBad;
    endfunction

    // only the first fault is remembered; any open sequence is dropped
    function void raise_error(logic [63:0] where);
      if (!err_seen) begin
        err_seen = 1'b1;
        err_pos  = where & POS_MAX;
      end
      due     = 0;
      seq_len = 0;
      cp_acc  = '0;
    endfunction

    function void open_seq(int unsigned n, logic [20:0] bits, logic [63:0] pos);
      seq_len   = n;
      due       = n - 1;
      cp_acc    = bits;
      seq_start = pos;
    endfunction

    // overlong, surrogate and out-of-range checks once the last continuation is in
    function void close_seq();
      logic [20:0] floor_cp;
      floor_cp = (seq_len == 2) ? 21'h00080 : ((seq_len == 3) ? 21'h00800 : 21'h10000);
      if (cp_acc < floor_cp || (cp_acc >= 21'h0D800 && cp_acc <= 21'h0DFFF) ||
          cp_acc > 21'h10FFFF) begin
        raise_error(seq_start);
      end
      seq_len = 0;
      cp_acc  = '0;
    endfunction

    function void note_byte(u8_t b, bit last);
      logic [63:0] pos;
      verdict_t    v;
      pos = byte_pos & POS_MAX;
      if (!err_seen) begin
        if (due == 0) begin
          case (lead_kind(b))
            suv_pkg::LeadAscii: ;
            suv_pkg::LeadTwo:   open_seq(2, {16'd0, b[4:0]}, pos);
            suv_pkg::LeadThree: open_seq(3, {17'd0, b[3:0]}, pos);
            suv_pkg::LeadFour:  open_seq(4, {18'd0, b[2:0]}, pos);
            default:            raise_error(pos);
          endcase
        end else if (b[7:6] != 2'b10) begin
          raise_error(seq_start);
        end else begin
          cp_acc = {cp_acc[14:0], b[5:0]};
          due--;
          if (due == 0) begin
            close_seq();
          end
        end
        // string ends inside a sequence: blame its lead byte
        if (last && !err_seen && due != 0) begin
          raise_error(seq_start);
        end
      end
      if (last) begin
        v.malformed = err_seen;
        v.offset    = err_seen ? err_pos[31:0] : 32'd0;
        verdict_q.insert(verdict_q.size(), v);
        restart();
      end else begin
        byte_pos = (pos >= POS_MAX) ? POS_MAX : pos + 64'd1;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void check_result(bit malformed, logic [31:0] offset);
      verdict_t v;
      n_results++;
      if (malformed) begin
        n_malformed++;
      end
      if (verdict_q.size() == 0) begin
        report($sformatf("mismatch: unexpected result malformed=%0b offset=%0d",
                         malformed, offset));
      end else begin
        v = verdict_q.pop_front();
        if (malformed !== v.malformed) begin
          report($sformatf("mismatch: malformed expected %0b actual %0b",
                           v.malformed, malformed));
        end
        if (offset !== v.offset) begin
          report($sformatf("mismatch: bad_offset expected %0d actual %0d",
                           v.offset, offset));
        end
      end
    endfunction
  endclass

  // clock, reset and the block's inputs, all known from time zero
  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;    // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [31:0] bad_offset
  logic [0:0]  m_axis_tuser;            // [0] malformed

  // flow-control knobs; the two rates are percentages out of a hundred
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  bit          hold_go       = 1'b0;
  logic        hold_on       = 1'b0;

  utf8_scoreboard sb;
  u8_t            text_q[$];      // bytes of the string being built
  int unsigned    n_strings = 0;
  int unsigned    n_bytes   = 0;

  strict_utf8_validator #(
    .OFFSET_BITS (OFFSET_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3000000;
    $display("FAIL strict_utf8_validator");
    $finish;
  end

  // long receiver hold-off, counted here so the sender carries on meanwhile
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // receiver: checks each result transaction and picks the next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      sb.check_result(m_axis_tuser[0], m_axis_tdata);
    end
    if (hold_on) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // append one byte to the string being built
  function automatic void append_byte(u8_t b);
    text_q.insert(text_q.size(), b);
  endfunction

  // push a sequence of n bytes for cp, keeping only its first keep bytes
  function automatic void push_seq(int unsigned n, logic [20:0] cp, int unsigned keep);
    u8_t enc[4];
    case (n)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int unsigned i = 0; i < keep; i++) begin
      append_byte(enc[i]);
    end
  endfunction

  // a legal code point in its shortest form, for a given length
  function automatic logic [20:0] legal_cp(int unsigned n);
    logic [20:0] cp;
    case (n)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= 21'h0D800 && cp <= 21'h0DFFF) begin
          cp = 21'hE000 | cp[10:0];
        end
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic void add_legal_char();
    int unsigned n;
    n = $urandom_range(1, 4);
    push_seq(n, legal_cp(n), n);
  endfunction

  // one malformed construct of a random kind
  function automatic void add_fault();
    int unsigned n;
    int unsigned kind;
    u8_t         b;
    kind = $urandom_range(0, 6);
    n    = $urandom_range(2, 4);
    case (kind)
      0: append_byte(8'h80 | 8'($urandom_range(0, 'h3F)));           // stray continuation
      1: append_byte(8'($urandom_range('hF8, 'hFF)));                // lead never legal
      2: push_seq(n, (n == 2) ? 21'($urandom_range(0, 'h7F))          // overlong
                   : ((n == 3) ? 21'($urandom_range(0, 'h7FF))
                               : 21'($urandom_range(0, 'hFFFF))), n);
      3: push_seq(3, 21'($urandom_range('hD800, 'hDFFF)), 3);       // surrogate
      4: push_seq(4, 21'($urandom_range('h110000, 'h1FFFFF)), 4);   // beyond U+10FFFF
      5: begin                                                        // broken continuation
        push_seq(n, legal_cp(n), $urandom_range(1, n - 1));
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b[7:6] == 2'b10);
        append_byte(b);
      end
      default: push_seq(n, legal_cp(n), $urandom_range(1, n - 1));    // cut short
    endcase
  endfunction

  // mostly well-formed text, some with one fault, a few truncated or pure noise
  function automatic void build_random_text();
    int unsigned style;
    int unsigned n_chars;
    int unsigned fault_at;
    int unsigned n;
    text_q.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      n_chars  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      fault_at = (style <= 3) ? $urandom_range(0, n_chars - 1) : n_chars;
      for (int unsigned i = 0; i < n_chars; i++) begin
        if (i == fault_at) begin
          add_fault();
        end else begin
          add_legal_char();
        end
      end
      if (style == 4) begin
        n = $urandom_range(2, 4);
        push_seq(n, legal_cp(n), $urandom_range(1, n - 1));
      end
    end
  endfunction

  // offer one byte, with random idle cycles first, and wait for the transaction
  task automatic send_byte(u8_t b, bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    sb.note_byte(b, last);
    n_bytes++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    n_strings++;
  endtask

  // sender goes quiet until every verdict owed has been seen
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned phase_start;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings, no idling
    text_q = '{8'h7F, 8'hC2, 8'h80};          send_text();  // ascii edge and smallest pair
    text_q = '{8'hC1, 8'hBF};                 send_text();  // overlong pair
    text_q = '{8'hE0, 8'h80, 8'h80};          send_text();  // overlong triple
    text_q = '{8'hED, 8'hA0, 8'h80};          send_text();  // first surrogate
    text_q = '{8'hF4, 8'h90, 8'h80, 8'h80};   send_text();  // just past U+10FFFF
    text_q = '{8'hF8};                        send_text();  // illegal lead alone
    text_q = '{8'h41, 8'h80, 8'h41};          send_text();  // stray continuation mid-string
    text_q = '{8'hC2, 8'h41};                 send_text();  // continuation missing
    text_q = '{8'h41, 8'hE2, 8'h82};          send_text();  // cut short by the end
    text_q = '{8'hF0, 8'h8F, 8'hBF, 8'hBF};   send_text();  // overlong quad
    drain_results();

    // random traffic in four flow-control phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 59; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 59; end
        default: begin src_idle_pct = 35; snk_stall_pct = 35; end
      endcase
      phase_start = n_bytes;
      if (ph == 0) begin
        // hold the receiver off while short strings keep coming, to back up the input
        hold_go = 1'b1;
        repeat (30) begin
          text_q.delete();
          add_legal_char();
          send_text();
        end
        drain_results();
      end
      while (n_bytes - phase_start < PHASE_BYTES) begin
        build_random_text();
        send_text();
      end
      drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk_i);

    $display("covered %0d strings of %0d bytes, %0d verdicts of which %0d malformed",
             n_strings, n_bytes, sb.n_results, sb.n_malformed);
    $display("flow control: free running, idle sender, stalling receiver, both, plus a hold-off");
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("PASS strict_utf8_validator");
    end else begin
      $display("%0d mismatches", sb.n_fail);
      $display("FAIL strict_utf8_validator");
    end
    $finish;
  end

endmodule
